>>> src/packet_protocol_classifier_assert.svh
// Assertion macros shared by the classifier's checker.
// Needs nothing else; each macro expands to one concurrent assertion with a clock and reset.
`ifndef PACKET_PROTOCOL_CLASSIFIER_ASSERT_SVH
`define PACKET_PROTOCOL_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("classifier assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("classifier assertion failed");

`endif

>>> src/pcls_pkg.sv
// Package for the packet protocol classifier: widths, header offsets, codes and types.
// Used by every module of the block; depends on nothing.
package pcls_pkg;

	localparam int POS_W  = 16;
	localparam int BASE_W = 7;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [15:0] ET_IPV4 = 16'h0800;
	localparam logic [15:0] ET_ARP  = 16'h0806;
	localparam logic [15:0] ET_IPV6 = 16'h86DD;

	localparam logic [POS_W-1:0] POS_ET_HI    = 16'd12;
	localparam logic [POS_W-1:0] POS_ET_LO    = 16'd13;
	localparam logic [POS_W-1:0] POS_IHL      = 16'd14;
	localparam logic [POS_W-1:0] POS_V6_NEXT  = 16'd20;
	localparam logic [POS_W-1:0] POS_V4_PROTO = 16'd23;

	localparam logic [POS_W-1:0] ETH_HDR_LEN  = 16'd14;
	localparam logic [POS_W-1:0] IPV4_MIN_LEN = 16'd34;
	localparam logic [POS_W-1:0] IPV6_MIN_LEN = 16'd54;

	localparam logic [BASE_W-1:0] V4_L4_BASE = 7'd14;
	localparam logic [BASE_W-1:0] V6_L4_BASE = 7'd54;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [15:0] PORT_HTTP   = 16'd80;
	localparam logic [15:0] PORT_HTTPS  = 16'd443;
	localparam logic [15:0] PORT_DNS    = 16'd53;
	localparam logic [15:0] PORT_DHCP_S = 16'd67;
	localparam logic [15:0] PORT_DHCP_C = 16'd68;

	typedef enum logic [3:0] {
		CLS_UNKNOWN = 4'd0,
		CLS_ARP     = 4'd1,
		CLS_IPV4    = 4'd2,
		CLS_IPV6    = 4'd3,
		CLS_TCP     = 4'd4,
		CLS_UDP     = 4'd5,
		CLS_HTTP    = 4'd6,
		CLS_HTTPS   = 4'd7,
		CLS_DNS     = 4'd8,
		CLS_DHCP    = 4'd9
	} class_t;

	// Frame state as it stands after the byte in the input register is taken in.
	typedef struct packed {
		logic [POS_W-1:0]  len;
		logic [15:0]       eth_type;
		logic              ip;
		logic [BASE_W-1:0] base;
		logic [7:0]        protocol;
		logic [15:0]       l4_src;
		logic [15:0]       l4_dst;
	} frame_info_t;

endpackage

>>> src/pcls_capture.sv
// Per-frame byte counter and header field capture for the packet protocol classifier.
// Depends on pcls_pkg; holds the frame state and shows it as updated by the current byte.
module pcls_capture import pcls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        last,
	input  logic [7:0]  data,
	output frame_info_t info
);

	logic [POS_W-1:0]  pos_q;
	logic [15:0]       et_q;
	logic [3:0]        hw_q;
	logic [7:0]        proto_q;
	logic [15:0]       sp_q;
	logic [15:0]       dp_q;

	logic [15:0]       et_n;
	logic [3:0]        hw_n;
	logic [7:0]        proto_n;
	logic [15:0]       sp_n;
	logic [15:0]       dp_n;
	logic              past_eth;
	logic              is_v4;
	logic              is_v6;
	logic [BASE_W-1:0] base;
	logic [POS_W-1:0]  base_p0;
	logic [POS_W-1:0]  base_p1;
	logic [POS_W-1:0]  base_p2;
	logic [POS_W-1:0]  base_p3;
	logic [POS_W-1:0]  len;

	always_comb begin
		et_n = et_q;
		if (pos_q == POS_ET_HI) begin
			et_n = {data, et_q[7:0]};
		end else if (pos_q == POS_ET_LO) begin
			et_n = {et_q[15:8], data};
		end
		hw_n     = (pos_q == POS_IHL) ? data[3:0] : hw_q;
		past_eth = (pos_q >= POS_IHL);
		is_v4    = past_eth && (et_n == ET_IPV4);
		is_v6    = past_eth && (et_n == ET_IPV6);
		base     = is_v4 ? (V4_L4_BASE + {1'b0, hw_n, 2'b00}) : V6_L4_BASE;
		base_p0  = {{(POS_W-BASE_W){1'b0}}, base};
		base_p1  = base_p0 + 16'd1;
		base_p2  = base_p0 + 16'd2;
		base_p3  = base_p0 + 16'd3;

		proto_n = proto_q;
		if ((is_v4 && pos_q == POS_V4_PROTO) || (is_v6 && pos_q == POS_V6_NEXT)) begin
			proto_n = data;
		end
		sp_n = sp_q;
		dp_n = dp_q;
		if (is_v4 || is_v6) begin
			if (pos_q == base_p0) sp_n[15:8] = data;
			if (pos_q == base_p1) sp_n[7:0]  = data;
			if (pos_q == base_p2) dp_n[15:8] = data;
			if (pos_q == base_p3) dp_n[7:0]  = data;
		end
		len = (pos_q == POS_MAX) ? POS_MAX : pos_q + 16'd1;
	end

	assign info = '{
		len:      len,
		eth_type: et_n,
		ip:       is_v4 || is_v6,
		base:     base,
		protocol: proto_n,
		l4_src:   sp_n,
		l4_dst:   dp_n
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			et_q    <= '0;
			hw_q    <= '0;
			proto_q <= '0;
			sp_q    <= '0;
			dp_q    <= '0;
		end else if (step) begin
			if (last) begin
				pos_q   <= '0;
				et_q    <= '0;
				hw_q    <= '0;
				proto_q <= '0;
				sp_q    <= '0;
				dp_q    <= '0;
			end else begin
				pos_q   <= len;
				et_q    <= et_n;
				hw_q    <= hw_n;
				proto_q <= proto_n;
				sp_q    <= sp_n;
				dp_q    <= dp_n;
			end
		end
	end

endmodule

>>> src/pcls_classify.sv
// Classification of a finished frame for the packet protocol classifier.
// Depends on pcls_pkg; purely combinational, from the captured frame state to the result fields.
module pcls_classify import pcls_pkg::*; (
	input  frame_info_t info,
	output class_t      cls,
	output logic [15:0] eth_type,
	output logic [7:0]  next_protocol,
	output logic [15:0] source_port,
	output logic [15:0] destination_port
);

	logic [POS_W-1:0] need_sp;
	logic [POS_W-1:0] need_dp;
	logic             has_sp;
	logic             ports;
	logic             ip_long;
	logic             tcp_http;
	logic             tcp_https;
	logic             any_dns;
	logic             udp_dhcp;

	always_comb begin
		need_sp   = {{(POS_W-BASE_W){1'b0}}, info.base} + 16'd2;
		need_dp   = {{(POS_W-BASE_W){1'b0}}, info.base} + 16'd4;
		has_sp    = info.len >= need_sp;
		ports     = info.len >= need_dp;
		ip_long   = (info.eth_type == ET_IPV4 && info.len >= IPV4_MIN_LEN) ||
			(info.eth_type == ET_IPV6 && info.len >= IPV6_MIN_LEN);
		tcp_http  = info.l4_src == PORT_HTTP  || info.l4_dst == PORT_HTTP;
		tcp_https = info.l4_src == PORT_HTTPS || info.l4_dst == PORT_HTTPS;
		any_dns   = info.l4_src == PORT_DNS   || info.l4_dst == PORT_DNS;
		udp_dhcp  = info.l4_src == PORT_DHCP_S || info.l4_dst == PORT_DHCP_S ||
			info.l4_src == PORT_DHCP_C || info.l4_dst == PORT_DHCP_C;

		cls              = CLS_UNKNOWN;
		eth_type         = '0;
		next_protocol    = '0;
		source_port      = '0;
		destination_port = '0;

		if (info.len >= ETH_HDR_LEN) begin
			eth_type = info.eth_type;
			if (info.ip) begin
				next_protocol = info.protocol;
				if (has_sp) source_port = info.l4_src;
				if (ports) destination_port = info.l4_dst;
			end
			if (info.eth_type == ET_ARP) begin
				cls = CLS_ARP;
			end else if (ip_long) begin
				if (info.protocol == PROTO_TCP) begin
					cls = CLS_TCP;
					if (ports && tcp_http) begin
						cls = CLS_HTTP;
					end else if (ports && tcp_https) begin
						cls = CLS_HTTPS;
					end else if (ports && any_dns) begin
						cls = CLS_DNS;
					end
				end else if (info.protocol == PROTO_UDP) begin
					cls = CLS_UDP;
					if (ports && any_dns) begin
						cls = CLS_DNS;
					end else if (ports && udp_dhcp) begin
						cls = CLS_DHCP;
					end
				end else begin
					cls = (info.eth_type == ET_IPV4) ? CLS_IPV4 : CLS_IPV6;
				end
			end
		end
	end

endmodule

>>> src/packet_protocol_classifier.sv
// Top level of the packet protocol classifier: input register, frame capture, classification
// and result register. Depends on pcls_pkg, pcls_capture and pcls_classify.
//
// The block takes an Ethernet frame one byte per transaction and, for the byte marked last,
// delivers one result transaction with the class, EtherType, protocol byte, both L4 ports and
// the frame length. It accepts one byte every clock cycle unless stalled as below. The accepting
// edge loads a byte into the input register; when the last byte advances out of it, that edge
// loads the result register, from which the result is shown. The input stalls only while a
// last byte sits in the input register and the previous result is still held in the result
// register and not yet taken; bytes offered behind it wait as well.
module packet_protocol_classifier import pcls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  class_code,
	output logic [15:0] eth_type,
	output logic [7:0]  next_protocol,
	output logic [15:0] source_port,
	output logic [15:0] destination_port,
	output logic [15:0] frame_length
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        advance;
	frame_info_t info;
	class_t      cls;
	logic [15:0] et_c;
	logic [7:0]  np_c;
	logic [15:0] sp_c;
	logic [15:0] dp_c;

	logic        out_valid_q;
	logic [3:0]  class_q;
	logic [15:0] et_q;
	logic [7:0]  np_q;
	logic [15:0] sp_q;
	logic [15:0] dp_q;
	logic [15:0] len_q;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	pcls_capture u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.last   (last_s1),
		.data   (data_s1),
		.info   (info)
	);

	pcls_classify u_classify (
		.info             (info),
		.cls              (cls),
		.eth_type         (et_c),
		.next_protocol    (np_c),
		.source_port      (sp_c),
		.destination_port (dp_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			class_q <= cls;
			et_q    <= et_c;
			np_q    <= np_c;
			sp_q    <= sp_c;
			dp_q    <= dp_c;
			len_q   <= info.len;
		end
	end

	assign out_valid        = out_valid_q;
	assign class_code       = class_q;
	assign eth_type         = et_q;
	assign next_protocol    = np_q;
	assign source_port      = sp_q;
	assign destination_port = dp_q;
	assign frame_length     = len_q;

endmodule

>>> src/pcls_checker.sv
// Port-level checker for the packet protocol classifier, bound to the top level.
// Depends on pcls_pkg and the assertion macros in packet_protocol_classifier_assert.svh.
`include "packet_protocol_classifier_assert.svh"

module pcls_checker import pcls_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  class_code,
	input logic [15:0] eth_type,
	input logic [7:0]  next_protocol,
	input logic [15:0] source_port,
	input logic [15:0] destination_port,
	input logic [15:0] frame_length
);

	`PCLS_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid && $stable(class_code) && $stable(frame_length) && $stable(source_port))

	`PCLS_ASSERT_NOW(a_short_frame_unknown, clk, arst_n, out_valid && frame_length < ETH_HDR_LEN, class_code == CLS_UNKNOWN && eth_type == 16'd0 && next_protocol == 8'd0)

	`PCLS_ASSERT_NOW(a_arp_ethertype, clk, arst_n, out_valid && class_code == CLS_ARP, eth_type == ET_ARP)

	`PCLS_ASSERT_NOW(a_ip_class_ethertype, clk, arst_n, out_valid && class_code != CLS_UNKNOWN && class_code != CLS_ARP, eth_type == ET_IPV4 || eth_type == ET_IPV6)

endmodule

bind packet_protocol_classifier pcls_checker u_pcls_checker (.*);

>>> sim/pcls_frame_checker.sv
// Checker for the packet protocol classifier: follows the byte and result channels,
// predicts the class and captured fields of each frame and compares every result.
// Depends on pcls_pkg for widths, header offsets, EtherTypes, ports and class codes.
`timescale 1ns / 100ps

module pcls_frame_checker import pcls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  class_code,
	input  logic [15:0] eth_type,
	input  logic [7:0]  next_protocol,
	input  logic [15:0] source_port,
	input  logic [15:0] destination_port,
	input  logic [15:0] frame_length,
	output int          error_count,
	output int          pending_results
);

	typedef struct packed {
		class_t      cls;
		logic [15:0] et;
		logic [7:0]  proto;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] len;
	} frame_result_t;

	frame_result_t    expected_results[$];
	frame_result_t    oldest;
	logic [POS_W-1:0] byte_pos;
	logic [15:0]      held_et;
	logic [3:0]       held_ihl;
	logic [7:0]       held_proto;
	logic [15:0]      held_sport;
	logic [15:0]      held_dport;

	task automatic clear_frame();
		byte_pos = '0;
		held_et = '0;
		held_ihl = '0;
		held_proto = '0;
		held_sport = '0;
		held_dport = '0;
	endtask

	function automatic logic either_port(input logic [15:0] a, b, p);
		return a == p || b == p;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t: %s", $time, msg);
	endtask

	// Takes in one frame byte and, on the last one, queues the classification of the frame.
	task automatic classify_byte(input logic [7:0] d, input logic last);
		int unsigned   pos;
		int unsigned   l4_base;
		int unsigned   len;
		logic          on_ip;
		frame_result_t r;
		pos = byte_pos;
		l4_base = 0;
		on_ip = 1'b0;
		if (pos == POS_ET_HI) held_et[15:8] = d;
		if (pos == POS_ET_LO) held_et[7:0] = d;
		if (pos == POS_IHL) held_ihl = d[3:0];
		if (pos >= ETH_HDR_LEN && held_et == ET_IPV4) begin
			on_ip = 1'b1;
			l4_base = V4_L4_BASE + 4 * held_ihl;
			if (pos == POS_V4_PROTO) held_proto = d;
		end else if (pos >= ETH_HDR_LEN && held_et == ET_IPV6) begin
			on_ip = 1'b1;
			l4_base = V6_L4_BASE;
			if (pos == POS_V6_NEXT) held_proto = d;
		end
		if (on_ip) begin
			if (pos == l4_base) held_sport[15:8] = d;
			if (pos == l4_base + 1) held_sport[7:0] = d;
			if (pos == l4_base + 2) held_dport[15:8] = d;
			if (pos == l4_base + 3) held_dport[7:0] = d;
		end
		len = (byte_pos == POS_MAX) ? pos : pos + 1;
		if (byte_pos != POS_MAX) byte_pos++;
		if (!last) return;

		r = '0;
		r.len = 16'(len);
		if (len >= ETH_HDR_LEN) begin
			r.et = held_et;
			if (on_ip) begin
				r.proto = held_proto;
				if (len >= l4_base + 2) r.sport = held_sport;
				if (len >= l4_base + 4) r.dport = held_dport;
			end
			if (held_et == ET_ARP) begin
				r.cls = CLS_ARP;
			end else if ((held_et == ET_IPV4 && len >= IPV4_MIN_LEN) ||
					(held_et == ET_IPV6 && len >= IPV6_MIN_LEN)) begin
				if (held_proto == PROTO_TCP) begin
					r.cls = CLS_TCP;
					if (len >= l4_base + 4) begin
						if (either_port(held_sport, held_dport, PORT_HTTP)) r.cls = CLS_HTTP;
						else if (either_port(held_sport, held_dport, PORT_HTTPS)) r.cls = CLS_HTTPS;
						else if (either_port(held_sport, held_dport, PORT_DNS)) r.cls = CLS_DNS;
					end
				end else if (held_proto == PROTO_UDP) begin
					r.cls = CLS_UDP;
					if (len >= l4_base + 4) begin
						if (either_port(held_sport, held_dport, PORT_DNS)) r.cls = CLS_DNS;
						else if (either_port(held_sport, held_dport, PORT_DHCP_S) ||
								either_port(held_sport, held_dport, PORT_DHCP_C))
							r.cls = CLS_DHCP;
					end
				end else begin
					r.cls = (held_et == ET_IPV4) ? CLS_IPV4 : CLS_IPV6;
				end
			end
		end
		expected_results.push_back(r);
		clear_frame();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			expected_results.delete();
			error_count = 0;
			pending_results = 0;
		end else begin
			if (in_valid && in_ready) classify_byte(data_byte, last_byte);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result transaction with no frame outstanding");
				end else begin
					oldest = expected_results.pop_front();
					if (class_code !== oldest.cls)
						report_mismatch($sformatf("class_code %0d, expected %0d",
							class_code, oldest.cls));
					if (eth_type !== oldest.et)
						report_mismatch($sformatf("eth_type %h, expected %h",
							eth_type, oldest.et));
					if (next_protocol !== oldest.proto)
						report_mismatch($sformatf("next_protocol %0d, expected %0d",
							next_protocol, oldest.proto));
					if (source_port !== oldest.sport)
						report_mismatch($sformatf("source_port %0d, expected %0d",
							source_port, oldest.sport));
					if (destination_port !== oldest.dport)
						report_mismatch($sformatf("destination_port %0d, expected %0d",
							destination_port, oldest.dport));
					if (frame_length !== oldest.len)
						report_mismatch($sformatf("frame_length %0d, expected %0d",
							frame_length, oldest.len));
				end
			end
			pending_results = expected_results.size();
		end
	end

endmodule

>>> sim/tb_packet_protocol_classifier.sv
// Top of the packet protocol classifier regression: clock, reset, frame stimulus and verdict.
// Depends on pcls_pkg, the packet_protocol_classifier block and the pcls_frame_checker module.
`timescale 1ns / 100ps

module tb_packet_protocol_classifier;
	import pcls_pkg::*;

	localparam int TOTAL_BYTES       = 950;
	localparam int MIN_RANDOM_FRAMES = 6;
	localparam int STALL_LIMIT       = 2000;
	localparam int DRAIN_CYCLES      = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  class_code;
	logic [15:0] eth_type;
	logic [7:0]  next_protocol;
	logic [15:0] source_port;
	logic [15:0] destination_port;
	logic [15:0] frame_length;
	int          error_count;
	int          pending_results;
	logic        calm = 1'b0;
	int          bytes_sent = 0;
	int          idle_cycles = 0;

	packet_protocol_classifier i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.class_code       (class_code),
		.eth_type         (eth_type),
		.next_protocol    (next_protocol),
		.source_port      (source_port),
		.destination_port (destination_port),
		.frame_length     (frame_length)
	);

	pcls_frame_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.class_code       (class_code),
		.eth_type         (eth_type),
		.next_protocol    (next_protocol),
		.source_port      (source_port),
		.destination_port (destination_port),
		.frame_length     (frame_length),
		.error_count      (error_count),
		.pending_results  (pending_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) out_ready <= calm || $urandom_range(99) >= 9;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("packet_protocol_classifier regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [15:0] pick_port();
		case ($urandom_range(9))
			0: return PORT_HTTP;
			1: return PORT_HTTPS;
			2: return PORT_DNS;
			3: return PORT_DHCP_S;
			4: return PORT_DHCP_C;
			default: return 16'($urandom);
		endcase
	endfunction

	// Builds a frame of random bytes with the given header fields laid over it, then sends it.
	task automatic send_frame(input logic [15:0] et, input logic [3:0] ihl,
			input logic [7:0] proto, input logic [15:0] sport, dport, input int len);
		logic [7:0]  frame_bytes[$];
		logic [31:0] ports;
		int          l4_base;
		ports = {sport, dport};
		for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
		l4_base = (et == ET_IPV6) ? V6_L4_BASE : V4_L4_BASE + 4 * ihl;
		if (et == ET_IPV4 || et == ET_IPV6)
			for (int k = 0; k < 4; k++)
				if (l4_base + k < len) frame_bytes[l4_base + k] = ports[31 - 8 * k -: 8];
		if (len > POS_ET_HI) frame_bytes[POS_ET_HI] = et[15:8];
		if (len > POS_ET_LO) frame_bytes[POS_ET_LO] = et[7:0];
		if (et == ET_IPV4 && len > POS_IHL) frame_bytes[POS_IHL] = {frame_bytes[POS_IHL][7:4], ihl};
		if (et == ET_IPV4 && len > POS_V4_PROTO) frame_bytes[POS_V4_PROTO] = proto;
		if (et == ET_IPV6 && len > POS_V6_NEXT) frame_bytes[POS_V6_NEXT] = proto;

		for (int i = 0; i < len; i++) begin
			while (!calm && $urandom_range(99) < 9) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= frame_bytes[i];
			last_byte <= (i == len - 1);
			@(posedge clk);
			while (!in_ready) @(posedge clk);
		end
		bytes_sent += len;
	endtask

	initial begin
		int          sel;
		int          need;
		int          len;
		logic [15:0] et;
		logic [3:0]  ihl;
		logic [7:0]  proto;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_frame(16'hFFFF, 4'd0, 8'd0, 16'd0, 16'd0, 1);
		send_frame(ET_IPV4, 4'd5, PROTO_TCP, PORT_HTTP, 16'd0, 13);
		send_frame(ET_ARP, 4'd5, 8'd0, 16'd0, 16'd0, 14);
		send_frame(ET_IPV4, 4'd5, PROTO_TCP, PORT_HTTP, PORT_HTTP, 33);
		send_frame(ET_IPV4, 4'd5, PROTO_TCP, PORT_HTTP, 16'd0, 34);
		send_frame(ET_IPV4, 4'd5, PROTO_TCP, PORT_HTTPS, PORT_HTTP, 38);
		send_frame(ET_IPV4, 4'd5, PROTO_TCP, 16'd5000, PORT_HTTPS, 38);
		send_frame(ET_IPV4, 4'd5, PROTO_TCP, PORT_DNS, 16'hFFFF, 38);
		send_frame(ET_IPV4, 4'd5, PROTO_UDP, PORT_DHCP_S, PORT_DNS, 38);
		send_frame(ET_IPV4, 4'd5, PROTO_UDP, 16'hFFFF, PORT_DHCP_C, 38);
		send_frame(ET_IPV4, 4'd5, PROTO_UDP, PORT_DNS, 16'd0, 37);
		send_frame(ET_IPV4, 4'd5, 8'd1, PORT_HTTP, 16'd0, 38);
		send_frame(ET_IPV6, 4'd5, 8'd58, 16'd0, 16'd0, 56);
		send_frame(ET_IPV6, 4'd5, PROTO_TCP, PORT_HTTPS, 16'd0, 53);
		send_frame(ET_IPV6, 4'd5, PROTO_TCP, 16'd1, PORT_HTTPS, 58);
		send_frame(ET_IPV4, 4'd0, PROTO_TCP, PORT_HTTP, PORT_HTTP, 34);
		send_frame(ET_IPV4, 4'd15, PROTO_UDP, PORT_DHCP_S, 16'd0, 78);
		send_frame(16'h0000, 4'd0, 8'd0, 16'd0, 16'd0, 20);

		// Mostly well-formed IPv4 and IPv6 frames, with ARP, truncated frames and stray EtherTypes.
		for (int n = 0; bytes_sent < TOTAL_BYTES || n < MIN_RANDOM_FRAMES; n++) begin
			calm = (n >= 2 && n < 6);
			if (n == 1) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_results != 0);
			end
			sel = $urandom_range(99);
			et = (sel < 40) ? ET_IPV4 : (sel < 65) ? ET_IPV6 : (sel < 75) ? ET_ARP : 16'($urandom);
			ihl = ($urandom_range(99) < 70) ? 4'd5 : 4'($urandom);
			sel = $urandom_range(99);
			proto = (sel < 40) ? PROTO_TCP : (sel < 75) ? PROTO_UDP : 8'($urandom);
			if (et == ET_IPV6) begin
				need = V6_L4_BASE + 4;
			end else if (et == ET_IPV4) begin
				need = V4_L4_BASE + 4 * ihl + 4;
				if (need < IPV4_MIN_LEN) need = IPV4_MIN_LEN;
			end else begin
				need = ETH_HDR_LEN + $urandom_range(40);
			end
			sel = $urandom_range(99);
			if (sel < 70) len = need + $urandom_range(16);
			else if (sel < 90) len = $urandom_range(need, 1);
			else len = $urandom_range(15, 1);
			send_frame(et, ihl, proto, pick_port(), pick_port(), len);
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results == 0) begin
			$display("packet_protocol_classifier regression: pass");
		end else begin
			$display("packet_protocol_classifier regression: fail");
		end
		$finish;
	end

endmodule
